/* hw/rtl/one_wire_master_with_crc8_defines.svh */
// Assertion macros for the one-wire master.
`ifndef ONE_WIRE_MASTER_WITH_CRC8_DEFINES_SVH
`define ONE_WIRE_MASTER_WITH_CRC8_DEFINES_SVH

`ifndef SYNTH
`define OWM_ASSERT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("one-wire master check failed");
`define OWM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("one-wire master check failed");
`else
`define OWM_ASSERT(lbl, ante, cons)
`define OWM_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* hw/rtl/owm_pkg.sv */
// Types, codes and helper functions shared by the one-wire master.
package owm_pkg;

	typedef enum logic [3:0] {
		PH_IDLE     = 4'd0,
		PH_RST_LOW  = 4'd1,
		PH_RST_REL  = 4'd2,
		PH_RST_HIGH = 4'd3,
		PH_WR_LOW   = 4'd4,
		PH_WR_HIGH  = 4'd5,
		PH_RD_LOW   = 4'd6,
		PH_RD_REL   = 4'd7,
		PH_RD_TAIL  = 4'd8,
		PH_WAIT_REL = 4'd9
	} owm_phase_t;

	localparam logic [2:0] REQ_TICK    = 3'd0;
	localparam logic [2:0] REQ_RESET   = 3'd1;
	localparam logic [2:0] REQ_WRITE   = 3'd2;
	localparam logic [2:0] REQ_READ    = 3'd3;
	localparam logic [2:0] REQ_WAITREL = 3'd4;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NOPRES = 2'd1;
	localparam logic [1:0] ST_BUSY   = 2'd2;

	localparam logic [7:0] CYCLES_PER_US_RST = 8'd204;
	localparam logic [7:0] CRC_POLY          = 8'h8C;

	localparam logic [8:0] T_RST_LOW  = 9'd480;
	localparam logic [8:0] T_RST_REL  = 9'd40;
	localparam logic [8:0] T_SHORT    = 9'd3;
	localparam logic [8:0] T_SLOT     = 9'd60;
	localparam logic [8:0] T_RECOVER  = 9'd10;
	localparam logic [8:0] T_RD_REL   = 9'd12;
	localparam logic [8:0] T_RD_TAIL  = 9'd55;

	typedef struct packed {
		logic       drive_low;
		logic       busy_res;
		logic       done_res;
		logic [1:0] status;
		logic [7:0] read_data;
		logic [7:0] crc_value;
		logic       crc_zero;
	} owm_result_t;

	function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] din);
		logic [7:0] c;
		logic [7:0] d;
		c = crc_in;
		d = din;
		for (int k = 0; k < 8; k++) begin
			if (c[0] ^ d[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
			d = d >> 1;
		end
		return c;
	endfunction

	function automatic logic [8:0] phase_len(input owm_phase_t ph, input logic one);
		logic [8:0] len;
		case (ph)
			PH_RST_LOW: len = T_RST_LOW;
			PH_RST_REL: len = T_RST_REL;
			PH_WR_LOW:  len = one ? T_SHORT : T_SLOT;
			PH_WR_HIGH: len = one ? T_SLOT : T_RECOVER;
			PH_RD_LOW:  len = T_SHORT;
			PH_RD_REL:  len = T_RD_REL;
			default:    len = T_RD_TAIL;
		endcase
		return len;
	endfunction

endpackage

/* hw/rtl/owm_core.sv */
// Bus sequencer, microsecond prescaler and read CRC of the one-wire master.
module owm_core
	import owm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        take,
	input  logic [2:0]  req_type,
	input  logic [7:0]  data_byte,
	input  logic        line_level,
	input  logic [7:0]  cycles_per_us,
	output owm_result_t res
);

	owm_phase_t ph_q, ph_d;
	logic [7:0] pre_q, pre_d;
	logic [8:0] us_q, us_d;
	logic [2:0] bit_q, bit_d;
	logic [7:0] sh_q, sh_d;
	logic [7:0] crc_q, crc_d;
	logic [1:0] st_q, st_d;
	logic [7:0] rd_q, rd_d;
	logic       done;
	logic       is_req;
	logic [8:0] div9;
	logic [8:0] pre_inc;
	logic [8:0] us_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q  <= PH_IDLE;
			pre_q <= '0;
			us_q  <= '0;
			bit_q <= '0;
			sh_q  <= '0;
			crc_q <= '0;
			st_q  <= ST_OK;
			rd_q  <= '0;
		end else if (take) begin
			ph_q  <= ph_d;
			pre_q <= pre_d;
			us_q  <= us_d;
			bit_q <= bit_d;
			sh_q  <= sh_d;
			crc_q <= crc_d;
			st_q  <= st_d;
			rd_q  <= rd_d;
		end
	end

	assign is_req  = (req_type == REQ_RESET) || (req_type == REQ_WRITE) ||
	                 (req_type == REQ_READ) || (req_type == REQ_WAITREL);
	assign div9    = (cycles_per_us == 8'd0) ? 9'd1 : {1'b0, cycles_per_us};
	assign pre_inc = {1'b0, pre_q} + 9'd1;
	assign us_inc  = us_q + 9'd1;

	always_comb begin
		ph_d  = ph_q;
		pre_d = pre_q;
		us_d  = us_q;
		bit_d = bit_q;
		sh_d  = sh_q;
		crc_d = crc_q;
		st_d  = st_q;
		rd_d  = rd_q;
		done  = 1'b0;
		if (is_req) begin
			if (ph_q != PH_IDLE) begin
				st_d = ST_BUSY;
			end else begin
				pre_d = '0;
				us_d  = '0;
				bit_d = '0;
				unique case (req_type)
					REQ_RESET: begin
						crc_d = '0;
						ph_d  = PH_RST_LOW;
					end
					REQ_WRITE: begin
						sh_d = data_byte;
						ph_d = PH_WR_LOW;
					end
					REQ_READ: begin
						sh_d = '0;
						ph_d = PH_RD_LOW;
					end
					default: begin
						ph_d = PH_WAIT_REL;
					end
				endcase
			end
		end else begin
			unique case (ph_q) inside
				PH_IDLE: begin
				end
				PH_RST_HIGH, PH_WAIT_REL: begin
					if (line_level) begin
						ph_d = PH_IDLE;
						st_d = ST_OK;
						done = 1'b1;
					end
				end
				PH_RST_LOW, PH_RST_REL, PH_WR_LOW, PH_WR_HIGH,
				PH_RD_LOW, PH_RD_REL, PH_RD_TAIL: begin
					pre_d = pre_inc[7:0];
					if (pre_inc >= div9) begin
						pre_d = '0;
						us_d  = us_inc;
						if (us_inc >= phase_len(ph_q, sh_q[0])) begin
							us_d = '0;
							unique case (ph_q) inside
								PH_RST_LOW: ph_d = PH_RST_REL;
								PH_RST_REL: begin
									if (line_level) begin
										ph_d = PH_IDLE;
										st_d = ST_NOPRES;
										done = 1'b1;
									end else begin
										ph_d = PH_RST_HIGH;
									end
								end
								PH_WR_LOW: ph_d = PH_WR_HIGH;
								PH_WR_HIGH: begin
									sh_d = sh_q >> 1;
									if (bit_q == 3'd7) begin
										bit_d = '0;
										ph_d  = PH_IDLE;
										st_d  = ST_OK;
										done  = 1'b1;
									end else begin
										bit_d = bit_q + 3'd1;
										ph_d  = PH_WR_LOW;
									end
								end
								PH_RD_LOW: ph_d = PH_RD_REL;
								PH_RD_REL: begin
									sh_d = {line_level, sh_q[7:1]};
									ph_d = PH_RD_TAIL;
								end
								PH_RD_TAIL: begin
									if (bit_q == 3'd7) begin
										bit_d = '0;
										rd_d  = sh_q;
										crc_d = crc8_byte(crc_q, sh_q);
										ph_d  = PH_IDLE;
										st_d  = ST_OK;
										done  = 1'b1;
									end else begin
										bit_d = bit_q + 3'd1;
										ph_d  = PH_RD_LOW;
									end
								end
								default: ph_d = PH_IDLE;
							endcase
						end
					end
				end
				default: begin
					ph_d = PH_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		res.drive_low = (ph_d == PH_RST_LOW) || (ph_d == PH_WR_LOW) || (ph_d == PH_RD_LOW);
		res.busy_res  = (ph_d != PH_IDLE);
		res.done_res  = done;
		res.status    = st_d;
		res.read_data = rd_d;
		res.crc_value = crc_d;
		res.crc_zero  = (crc_d == 8'd0);
	end

endmodule

/* hw/rtl/one_wire_master_with_crc8.sv */
// One-wire bus master with running CRC-8: top level with config and output buffer.
// Every accepted item (a clock tick carrying the sampled bus level, or a request)
// produces exactly one result item. The sequencer state advances in the cycle the
// item is accepted and the result lands in a two-entry output buffer, so one item
// is taken every cycle while a buffer entry is free; in_ready drops only when both
// buffer entries are full. Bus timing counts ticks: cycles_per_us ticks make one
// microsecond (0 acts as 1).
`include "one_wire_master_with_crc8_defines.svh"

module one_wire_master_with_crc8
	import owm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] req_type,
	input  logic [7:0] data_byte,
	input  logic       line_level,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       drive_low,
	output logic       busy_res,
	output logic       done_res,
	output logic [1:0] status,
	output logic [7:0] read_data,
	output logic [7:0] crc_value,
	output logic       crc_zero
);

	logic [7:0]  cpu_q;
	logic        take;
	owm_result_t res;
	owm_result_t out_q;
	owm_result_t skid_q;
	logic        out_valid_q;
	logic        skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpu_q <= CYCLES_PER_US_RST;
		end else if (cfg_wr_en) begin
			cpu_q <= cfg_wr_data;
		end
	end

	assign in_ready = !skid_valid_q;
	assign take     = in_valid && in_ready;

	owm_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (take),
		.req_type      (req_type),
		.data_byte     (data_byte),
		.line_level    (line_level),
		.cycles_per_us (cpu_q),
		.res           (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_valid_q && out_ready) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= take;
			end
		end else if (take) begin
			if (out_valid_q) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_valid_q && out_ready) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (take) begin
				out_q <= res;
			end
		end else if (take) begin
			if (out_valid_q) begin
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign drive_low = out_q.drive_low;
	assign busy_res  = out_q.busy_res;
	assign done_res  = out_q.done_res;
	assign status    = out_q.status;
	assign read_data = out_q.read_data;
	assign crc_value = out_q.crc_value;
	assign crc_zero  = out_q.crc_zero;

	`OWM_ASSERT(a_skid_needs_out, skid_valid_q, out_valid_q)
	`OWM_ASSERT_NEXT(a_stall_fills_skid, take && out_valid_q && !out_ready, skid_valid_q)
	`OWM_ASSERT(a_drive_implies_busy, out_valid_q && out_q.drive_low, out_q.busy_res)
	`OWM_ASSERT(a_done_not_busy, out_valid_q && out_q.done_res, !out_q.busy_res)

endmodule

/* tb/sv/one_wire_master_with_crc8_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for the one-wire master: directed table, then random items, all predicted.
module one_wire_master_with_crc8_tb;
	import owm_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 3000000;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam logic [2:0] REQ_SPARE_LO = 3'd5;
	localparam logic [2:0] REQ_SPARE_HI = 3'd7;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		logic [2:0]  req;
		logic [7:0]  data;
		logic        lvl;
		int unsigned reps;
		logic        typed;
		owm_result_t want;
	} plan_row_t;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       cfg_wr_en = 1'b0;
	logic [7:0] cfg_wr_data = 8'd0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [2:0] req_type = REQ_TICK;
	logic [7:0] data_byte = 8'd0;
	logic       line_level = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       drive_low;
	logic       busy_res;
	logic       done_res;
	logic [1:0] status;
	logic [7:0] read_data;
	logic [7:0] crc_value;
	logic       crc_zero;

	owm_result_t pending_q[$];
	plan_row_t   plan[$];
	int unsigned mismatches = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned ops_done = 0;
	int unsigned cycle_count = 0;

	owm_phase_t bus_phase = PH_IDLE;
	logic [7:0] us_div = CYCLES_PER_US_RST;
	logic [7:0] tick_count = 8'd0;
	logic [8:0] usec = 9'd0;
	logic [2:0] bit_pos = 3'd0;
	logic [7:0] shreg = 8'd0;
	logic [7:0] crc_acc = 8'd0;
	logic [1:0] stat = ST_OK;
	logic [7:0] rd_byte = 8'd0;
	logic       read_aim = 1'b0;
	logic [7:0] read_target = 8'd0;

	one_wire_master_with_crc8 u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.data_byte(data_byte),
		.line_level(line_level),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.drive_low(drive_low),
		.busy_res(busy_res),
		.done_res(done_res),
		.status(status),
		.read_data(read_data),
		.crc_value(crc_value),
		.crc_zero(crc_zero)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc;
		for (int i = 0; i < 8; i++) begin
			c = (c[0] ^ b[i]) ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	function automatic owm_result_t bus_step(input logic [2:0] r, input logic [7:0] d,
			input logic l);
		owm_result_t res;
		logic        fin;
		logic [8:0]  len;
		logic [7:0]  div;
		fin = 1'b0;
		div = (us_div == 8'd0) ? 8'd1 : us_div;
		if (r >= REQ_RESET && r <= REQ_WAITREL) begin
			if (bus_phase != PH_IDLE) begin
				stat = ST_BUSY;
			end else begin
				tick_count = 8'd0;
				usec = 9'd0;
				bit_pos = 3'd0;
				case (r)
					REQ_RESET: begin
						crc_acc = 8'd0;
						bus_phase = PH_RST_LOW;
					end
					REQ_WRITE: begin
						shreg = d;
						bus_phase = PH_WR_LOW;
					end
					REQ_READ: begin
						shreg = 8'd0;
						bus_phase = PH_RD_LOW;
					end
					default: bus_phase = PH_WAIT_REL;
				endcase
			end
		end else if (bus_phase == PH_RST_HIGH || bus_phase == PH_WAIT_REL) begin
			if (l) begin
				bus_phase = PH_IDLE;
				stat = ST_OK;
				fin = 1'b1;
			end
		end else if (bus_phase != PH_IDLE) begin
			tick_count = tick_count + 8'd1;
			if (tick_count >= div) begin
				tick_count = 8'd0;
				usec = usec + 9'd1;
				case (bus_phase)
					PH_RST_LOW: len = T_RST_LOW;
					PH_RST_REL: len = T_RST_REL;
					PH_WR_LOW:  len = shreg[0] ? T_SHORT : T_SLOT;
					PH_WR_HIGH: len = shreg[0] ? T_SLOT : T_RECOVER;
					PH_RD_LOW:  len = T_SHORT;
					PH_RD_REL:  len = T_RD_REL;
					default:    len = T_RD_TAIL;
				endcase
				if (usec >= len) begin
					usec = 9'd0;
					case (bus_phase)
						PH_RST_LOW: bus_phase = PH_RST_REL;
						PH_RST_REL: begin
							if (l) begin
								bus_phase = PH_IDLE;
								stat = ST_NOPRES;
								fin = 1'b1;
							end else begin
								bus_phase = PH_RST_HIGH;
							end
						end
						PH_WR_LOW: bus_phase = PH_WR_HIGH;
						PH_WR_HIGH: begin
							shreg = shreg >> 1;
							if (bit_pos == 3'd7) begin
								bit_pos = 3'd0;
								bus_phase = PH_IDLE;
								stat = ST_OK;
								fin = 1'b1;
							end else begin
								bit_pos = bit_pos + 3'd1;
								bus_phase = PH_WR_LOW;
							end
						end
						PH_RD_LOW: bus_phase = PH_RD_REL;
						PH_RD_REL: begin
							shreg = {l, shreg[7:1]};
							bus_phase = PH_RD_TAIL;
						end
						default: begin
							if (bit_pos == 3'd7) begin
								bit_pos = 3'd0;
								rd_byte = shreg;
								crc_acc = crc_update(crc_acc, shreg);
								bus_phase = PH_IDLE;
								stat = ST_OK;
								fin = 1'b1;
							end else begin
								bit_pos = bit_pos + 3'd1;
								bus_phase = PH_RD_LOW;
							end
						end
					endcase
				end
			end
		end
		if (fin) begin
			ops_done++;
		end
		res.drive_low = (bus_phase == PH_RST_LOW || bus_phase == PH_WR_LOW ||
			bus_phase == PH_RD_LOW);
		res.busy_res = (bus_phase != PH_IDLE);
		res.done_res = fin;
		res.status = stat;
		res.read_data = rd_byte;
		res.crc_value = crc_acc;
		res.crc_zero = (crc_acc == 8'd0);
		return res;
	endfunction

	task automatic note_mismatch(input string what, input owm_result_t want,
			input owm_result_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%s at %0t: want dl=%b busy=%b done=%b st=%0d rd=%h crc=%h z=%b",
				what, $time, want.drive_low, want.busy_res, want.done_res, want.status,
				want.read_data, want.crc_value, want.crc_zero);
			$display("    got dl=%b busy=%b done=%b st=%0d rd=%h crc=%h z=%b",
				got.drive_low, got.busy_res, got.done_res, got.status,
				got.read_data, got.crc_value, got.crc_zero);
		end
	endtask

	always @(posedge clk) begin : check_results
		owm_result_t got;
		owm_result_t want;
		if (arst_n && out_valid && out_ready) begin
			got = {drive_low, busy_res, done_res, status, read_data, crc_value, crc_zero};
			if (pending_q.size() == 0) begin
				note_mismatch("unexpected item", 'x, got);
			end else begin
				want = pending_q.pop_front();
				if (got !== want) begin
					note_mismatch("wrong item", want, got);
				end
			end
		end
	end

	task automatic put_item(input logic [2:0] r, input logic [7:0] d, input logic l,
			input logic typed, input owm_result_t typed_res);
		owm_result_t res;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= r;
		data_byte <= d;
		line_level <= l;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		res = bus_step(r, d, l);
		pending_q.push_back(typed ? typed_res : res);
		@(negedge clk);
	endtask

	task automatic configure(input logic [7:0] value);
		in_valid <= 1'b0;
		while (pending_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		us_div = value;
	endtask

	task automatic add_step(input row_kind_t kind, input logic [2:0] r, input logic [7:0] d,
			input logic l, input int unsigned reps, input logic typed, input owm_result_t want);
		plan_row_t row;
		row.kind = kind;
		row.req = r;
		row.data = d;
		row.lvl = l;
		row.reps = reps;
		row.typed = typed;
		row.want = want;
		plan.push_back(row);
	endtask

	task automatic run_random(input int unsigned s_idle, input int unsigned r_stall);
		int unsigned n_items;
		int unsigned ops_start;
		logic [2:0]  r;
		logic [7:0]  d;
		logic        l;
		send_idle_pct = s_idle;
		recv_stall_pct = r_stall;
		configure(8'($urandom_range(0, 1)));
		n_items = 0;
		ops_start = ops_done;
		while (n_items < 40 || ops_done - ops_start < 1 || bus_phase != PH_IDLE) begin
			d = 8'($urandom);
			l = 1'($urandom_range(0, 1));
			if (bus_phase == PH_IDLE) begin
				if ($urandom_range(0, 99) < 15) begin
					r = ($urandom_range(0, 3) == 0) ? REQ_TICK :
						3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
				end else begin
					r = 3'($urandom_range(REQ_RESET, REQ_WAITREL));
					read_aim = ($urandom_range(0, 3) == 0);
					read_target = crc_acc;
				end
			end else if ($urandom_range(0, 99) < 3) begin
				r = 3'($urandom_range(REQ_RESET, REQ_WAITREL));
			end else begin
				r = ($urandom_range(0, 9) == 0) ?
					3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI)) : REQ_TICK;
				if (bus_phase == PH_RST_REL || bus_phase == PH_RST_HIGH ||
						bus_phase == PH_WAIT_REL) begin
					l = ($urandom_range(0, 3) == 0);
				end else if (bus_phase == PH_RD_REL && read_aim) begin
					l = read_target[bit_pos];
				end
			end
			put_item(r, d, l, 1'b0, '0);
			n_items++;
		end
	endtask

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("one_wire_master_with_crc8_tb NOT OK");
		$finish;
	end

	initial begin
		add_step(ROW_ITEM, REQ_TICK, 8'hFF, 1'b1, 1, 1'b1,
			{1'b0, 1'b0, 1'b0, ST_OK, 8'h00, 8'h00, 1'b1});
		add_step(ROW_ITEM, REQ_WAITREL, 8'h00, 1'b1, 1, 1'b1,
			{1'b0, 1'b1, 1'b0, ST_OK, 8'h00, 8'h00, 1'b1});
		add_step(ROW_ITEM, REQ_TICK, 8'h00, 1'b0, 1, 1'b1,
			{1'b0, 1'b1, 1'b0, ST_OK, 8'h00, 8'h00, 1'b1});
		add_step(ROW_ITEM, REQ_READ, 8'hFF, 1'b1, 1, 1'b1,
			{1'b0, 1'b1, 1'b0, ST_BUSY, 8'h00, 8'h00, 1'b1});
		add_step(ROW_ITEM, REQ_SPARE_HI, 8'hFF, 1'b1, 1, 1'b1,
			{1'b0, 1'b0, 1'b1, ST_OK, 8'h00, 8'h00, 1'b1});
		add_step(ROW_CFG, REQ_TICK, 8'd1, 1'b0, 0, 1'b0, '0);
		add_step(ROW_ITEM, REQ_RESET, 8'hFF, 1'b0, 1, 1'b0, '0);
		add_step(ROW_ITEM, REQ_TICK, 8'h00, 1'b0, 519, 1'b0, '0);
		add_step(ROW_ITEM, REQ_TICK, 8'h00, 1'b1, 1, 1'b1,
			{1'b0, 1'b0, 1'b1, ST_NOPRES, 8'h00, 8'h00, 1'b1});
		add_step(ROW_ITEM, REQ_RESET, 8'h00, 1'b1, 1, 1'b0, '0);
		add_step(ROW_ITEM, REQ_TICK, 8'hFF, 1'b0, 520, 1'b0, '0);
		add_step(ROW_ITEM, REQ_TICK, 8'h00, 1'b0, 3, 1'b0, '0);
		add_step(ROW_ITEM, REQ_TICK, 8'h00, 1'b1, 1, 1'b0, '0);
		add_step(ROW_CFG, REQ_TICK, 8'd0, 1'b0, 0, 1'b0, '0);
		add_step(ROW_ITEM, REQ_WRITE, 8'hA5, 1'b0, 1, 1'b0, '0);
		add_step(ROW_ITEM, REQ_TICK, 8'h00, 1'b1, 532, 1'b0, '0);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				configure(plan[i].data);
			end else begin
				for (int unsigned k = 0; k < plan[i].reps; k++) begin
					put_item(plan[i].req, plan[i].data, plan[i].lvl, plan[i].typed, plan[i].want);
				end
			end
		end

		run_random(0, 0);
		run_random(76, 0);
		run_random(0, 76);
		run_random(9, 9);

		in_valid <= 1'b0;
		while (pending_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatches == 0) begin
			$display("one_wire_master_with_crc8_tb OK");
		end else begin
			$display("one_wire_master_with_crc8_tb NOT OK");
		end
		$finish;
	end

endmodule
